// File: rtl/core/rsds_pkg.sv
// ----------------------------------------------------------------------------
// Read statistics sampler package
// Shared widths, field layouts, register indexes and helper functions.
// ----------------------------------------------------------------------------
package rsds_pkg;

  localparam int LEN_W    = 16;
  localparam int FLAGS_W  = 16;
  localparam int TGT_W    = 21;
  localparam int POS_W    = 31;
  localparam int QUAL_W   = 8;
  localparam int COUNT_W  = 32;
  localparam int BASE_W   = 48;
  localparam int SQ_W     = 64;
  localparam int PROD_W   = 2 * LEN_W;
  localparam int BUDGET_W = 30;
  localparam int CFG_DATA_W = 30;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 280;

  // Flag bit positions inside read_flags.
  localparam int FLAG_PAIRED   = 0;
  localparam int FLAG_UNMAPPED = 2;

  localparam logic [COUNT_W-1:0]  RATIO_MAX    = 32'h8000_0000;
  localparam logic [QUAL_W-1:0]   QUAL_RESET   = 8'd0;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 30'd4000000;

  typedef enum logic [0:0] {
    CFG_MIN_MAP_QUALITY = 1'b0,
    CFG_SAMPLE_BUDGET   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [LEN_W-1:0]        read_length;
    logic [FLAGS_W-1:0]      read_flags;
    logic signed [TGT_W-1:0] target_index;
    logic [POS_W-1:0]        target_position;
    logic [QUAL_W-1:0]       map_quality;
  } read_rec_t;

  typedef struct packed {
    logic [COUNT_W-1:0] total_reads;
    logic [BASE_W-1:0]  total_bases;
    logic [LEN_W-1:0]   shortest_read;
    logic [LEN_W-1:0]   longest_read;
    logic [COUNT_W-1:0] mapped_reads;
    logic               paired_flag;
  } cnt_res_t;

  typedef struct packed {
    logic [COUNT_W-1:0] unique_reads;
    logic               sorted_flag;
    logic               keep_this;
    logic [COUNT_W-1:0] decimation_ratio;
    logic               halve_now;
  } samp_res_t;

  function automatic logic [COUNT_W-1:0] sat_inc32(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == '1) ? v : v + COUNT_W'(1);
    return r;
  endfunction

  // A read is mapped when the unmapped bit is clear and the target is valid.
  function automatic logic is_mapped(input read_rec_t rec);
    logic m;
    m = !rec.read_flags[FLAG_UNMAPPED] && !rec.target_index[TGT_W-1];
    return m;
  endfunction

endpackage

// File: rtl/core/read_stats_decimating_sampler_top.sv
// ----------------------------------------------------------------------------
// Read statistics decimating sampler, top level
// One aligned-read record in, one running-statistics record out per beat.
// ----------------------------------------------------------------------------
// The slave stream carries one read record per beat; the master stream
// returns one statistics record per accepted beat, in order, holding the
// values after that read. Registers are written through cfg_we, cfg_addr
// and cfg_wdata; the user must do this only while the stream is idle, and
// the block does not enforce it. The pipeline has three register stages:
// an input register, a stage where the counters, the decimator and the
// squared length are formed, and the output register where the squared
// sum is added. Throughput is one beat per cycle while the receiver takes
// results; it is set by the counter and decimator state, which every read
// reads and writes and which is updated as each beat leaves the input stage.
// Each stage takes a new beat when it is empty or its successor moves, so a
// stalled receiver fills the pipeline before s_tready falls, and beats are
// accepted again as soon as the output register is taken.
// Synchronous reset clears all statistics, sets ratio and countdown to one,
// sets the sorted flag, loads the register defaults and empties the pipeline.
module read_stats_decimating_sampler_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // read_length[15:0], read_flags[31:16], target_index[52:32],
  // target_position[83:53], map_quality[91:84], zero pad[95:92]
  input  logic [rsds_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // total_reads[31:0], total_bases[79:32], total_squared_bases[143:80],
  // shortest_read[159:144], longest_read[175:160], mapped_reads[207:176],
  // unique_reads[239:208], sorted_flag[240], paired_flag[241],
  // keep_this[242], decimation_ratio[274:243], halve_now[275], zero pad[279:276]
  output logic [rsds_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 cfg_we,
  input  rsds_pkg::cfg_index_t                 cfg_addr,
  input  logic [rsds_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [rsds_pkg::QUAL_W-1:0]   min_map_quality;
  logic [rsds_pkg::BUDGET_W-1:0] sample_budget;

  rsds_pkg::read_rec_t s1_rec;
  logic                s1_valid, s2_valid;
  rsds_pkg::cnt_res_t  cnt_res, s2_cnt;
  rsds_pkg::samp_res_t samp_res, s2_samp;
  logic [rsds_pkg::SQ_W-1:0] sq_total;
  logic s1_ready, s2_ready, out_ready;
  logic s1_adv, s2_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_map_quality <= rsds_pkg::QUAL_RESET;
      sample_budget   <= rsds_pkg::BUDGET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rsds_pkg::CFG_MIN_MAP_QUALITY: min_map_quality <= cfg_wdata[rsds_pkg::QUAL_W-1:0];
        rsds_pkg::CFG_SAMPLE_BUDGET:   sample_budget   <= cfg_wdata[rsds_pkg::BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_ready = !m_tvalid || m_tready;
    s2_ready  = !s2_valid || out_ready;
    s1_ready  = !s1_valid || s2_ready;
    s1_adv    = s1_valid && s2_ready;
    s2_adv    = s2_valid && out_ready;
    s_tready  = s1_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= s_tvalid;
      if (s2_ready) s2_valid <= s1_valid;
      if (out_ready) m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s1_ready) begin
      s1_rec.read_length     <= s_tdata[15:0];
      s1_rec.read_flags      <= s_tdata[31:16];
      s1_rec.target_index    <= s_tdata[52:32];
      s1_rec.target_position <= s_tdata[83:53];
      s1_rec.map_quality     <= s_tdata[91:84];
    end
    if (s1_adv) begin
      s2_cnt  <= cnt_res;
      s2_samp <= samp_res;
    end
    if (s2_adv) begin
      m_tdata <= {4'b0000,
                  s2_samp.halve_now,
                  s2_samp.decimation_ratio,
                  s2_samp.keep_this,
                  s2_cnt.paired_flag,
                  s2_samp.sorted_flag,
                  s2_samp.unique_reads,
                  s2_cnt.mapped_reads,
                  s2_cnt.longest_read,
                  s2_cnt.shortest_read,
                  sq_total,
                  s2_cnt.total_bases,
                  s2_cnt.total_reads};
    end
  end

  rsds_counts u_counts (
    .clk (clk),
    .rst (rst),
    .adv (s1_adv),
    .rec (s1_rec),
    .res (cnt_res)
  );

  rsds_sampler u_sampler (
    .clk             (clk),
    .rst             (rst),
    .adv             (s1_adv),
    .rec             (s1_rec),
    .min_map_quality (min_map_quality),
    .sample_budget   (sample_budget),
    .res             (samp_res)
  );

  rsds_square u_square (
    .clk         (clk),
    .rst         (rst),
    .load        (s1_adv),
    .read_length (s1_rec.read_length),
    .adv         (s2_adv),
    .total_next  (sq_total)
  );

endmodule

// File: rtl/core/rsds_counts.sv
// ----------------------------------------------------------------------------
// Read statistics counters
// Read count, base sum, shortest and longest length, mapped count and the
// paired flag. Outputs give the values after the current beat.
// ----------------------------------------------------------------------------
module rsds_counts (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  rsds_pkg::read_rec_t rec,
  output rsds_pkg::cnt_res_t  res
);

  logic [rsds_pkg::COUNT_W-1:0] read_counter, read_counter_next;
  logic [rsds_pkg::COUNT_W-1:0] mapped_counter, mapped_counter_next;
  logic [rsds_pkg::BASE_W-1:0]  base_acc, base_acc_next;
  logic [rsds_pkg::BASE_W:0]    base_sum;
  logic [rsds_pkg::LEN_W-1:0]   min_len, min_len_next;
  logic [rsds_pkg::LEN_W-1:0]   max_len, max_len_next;
  logic                         paired_bit, paired_bit_next;
  logic                         first;

  always_comb begin
    first = (read_counter == '0);
    if (first) begin
      min_len_next = rec.read_length;
      max_len_next = rec.read_length;
    end else begin
      min_len_next = (rec.read_length < min_len) ? rec.read_length : min_len;
      max_len_next = (rec.read_length > max_len) ? rec.read_length : max_len;
    end
    base_sum = {1'b0, base_acc} + (rsds_pkg::BASE_W + 1)'(rec.read_length);
    base_acc_next = base_sum[rsds_pkg::BASE_W] ? '1 : base_sum[rsds_pkg::BASE_W-1:0];
    read_counter_next = rsds_pkg::sat_inc32(read_counter);
    mapped_counter_next = rsds_pkg::is_mapped(rec) ?
                          rsds_pkg::sat_inc32(mapped_counter) : mapped_counter;
    paired_bit_next = paired_bit | rec.read_flags[rsds_pkg::FLAG_PAIRED];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_counter   <= '0;
      mapped_counter <= '0;
      base_acc       <= '0;
      min_len        <= '0;
      max_len        <= '0;
      paired_bit     <= 1'b0;
    end else if (adv) begin
      read_counter   <= read_counter_next;
      mapped_counter <= mapped_counter_next;
      base_acc       <= base_acc_next;
      min_len        <= min_len_next;
      max_len        <= max_len_next;
      paired_bit     <= paired_bit_next;
    end
  end

  always_comb begin
    res.total_reads   = read_counter_next;
    res.total_bases   = base_acc_next;
    res.shortest_read = min_len_next;
    res.longest_read  = max_len_next;
    res.mapped_reads  = mapped_counter_next;
    res.paired_flag   = paired_bit_next;
  end

endmodule

// File: rtl/core/rsds_sampler.sv
// ----------------------------------------------------------------------------
// Read statistics decimating sampler
// Unique read count, adaptive keep decimator with halving, and the
// sorted-order check over kept reads.
// ----------------------------------------------------------------------------
module rsds_sampler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  rsds_pkg::read_rec_t             rec,
  input  logic [rsds_pkg::QUAL_W-1:0]     min_map_quality,
  input  logic [rsds_pkg::BUDGET_W-1:0]   sample_budget,
  output rsds_pkg::samp_res_t             res
);

  logic [rsds_pkg::COUNT_W-1:0] unique_counter, unique_counter_next;
  logic [rsds_pkg::COUNT_W-1:0] skip_countdown, skip_countdown_next;
  logic [rsds_pkg::COUNT_W-1:0] skip_ratio, skip_ratio_next;
  logic [rsds_pkg::COUNT_W-1:0] kept_count, kept_count_next;
  logic [rsds_pkg::TGT_W-1:0]   last_tgt, last_tgt_next;
  logic [rsds_pkg::POS_W-1:0]   last_pos, last_pos_next;
  logic                         have_kept, have_kept_next;
  logic                         sorted_bit, sorted_bit_next;
  logic                         is_unique, keep, halve;
  logic [rsds_pkg::COUNT_W-1:0] cd_dec, kept_inc, threshold;
  logic [rsds_pkg::TGT_W-1:0]   tgt_u;

  always_comb begin
    unique_counter_next = unique_counter;
    skip_countdown_next = skip_countdown;
    skip_ratio_next     = skip_ratio;
    kept_count_next     = kept_count;
    last_tgt_next       = last_tgt;
    last_pos_next       = last_pos;
    have_kept_next      = have_kept;
    sorted_bit_next     = sorted_bit;
    keep                = 1'b0;
    halve               = 1'b0;
    tgt_u     = rec.target_index;
    is_unique = rsds_pkg::is_mapped(rec) && (rec.map_quality > min_map_quality);
    cd_dec    = skip_countdown - rsds_pkg::COUNT_W'(1);
    kept_inc  = rsds_pkg::sat_inc32(kept_count);
    threshold = {1'b0, sample_budget, 1'b0};
    if (is_unique) begin
      unique_counter_next = rsds_pkg::sat_inc32(unique_counter);
      if (cd_dec == '0) begin
        keep = 1'b1;
        skip_countdown_next = skip_ratio;
        if (have_kept && ((last_tgt > tgt_u) ||
                          ((last_tgt == tgt_u) && (last_pos > rec.target_position)))) begin
          sorted_bit_next = 1'b0;
        end
        last_tgt_next  = tgt_u;
        last_pos_next  = rec.target_position;
        have_kept_next = 1'b1;
        if (kept_inc >= threshold) begin
          halve = 1'b1;
          kept_count_next = kept_inc >> 1;
          if (skip_ratio < rsds_pkg::RATIO_MAX) begin
            skip_ratio_next = skip_ratio << 1;
          end
        end else begin
          kept_count_next = kept_inc;
        end
      end else begin
        skip_countdown_next = cd_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unique_counter <= '0;
      skip_countdown <= rsds_pkg::COUNT_W'(1);
      skip_ratio     <= rsds_pkg::COUNT_W'(1);
      kept_count     <= '0;
      last_tgt       <= '0;
      last_pos       <= '0;
      have_kept      <= 1'b0;
      sorted_bit     <= 1'b1;
    end else if (adv) begin
      unique_counter <= unique_counter_next;
      skip_countdown <= skip_countdown_next;
      skip_ratio     <= skip_ratio_next;
      kept_count     <= kept_count_next;
      last_tgt       <= last_tgt_next;
      last_pos       <= last_pos_next;
      have_kept      <= have_kept_next;
      sorted_bit     <= sorted_bit_next;
    end
  end

  always_comb begin
    res.unique_reads     = unique_counter_next;
    res.sorted_flag      = sorted_bit_next;
    res.keep_this        = keep;
    res.decimation_ratio = skip_ratio_next;
    res.halve_now        = halve;
  end

  // The ratio only ever doubles from one, and the countdown restarts from it.
  a_ratio_pow2: assert property (@(posedge clk) disable iff (rst) $onehot(skip_ratio))
    else $error("skip ratio is not a power of two");
  a_countdown_range: assert property (@(posedge clk) disable iff (rst)
    (skip_countdown != '0) && (skip_countdown <= skip_ratio))
    else $error("skip countdown out of range");
  a_halve_keep: assert property (@(posedge clk) disable iff (rst)
    adv && halve |-> keep && is_unique)
    else $error("halving without a kept read");
  a_kept_marks: assert property (@(posedge clk) disable iff (rst)
    adv && keep |=> have_kept && (last_pos == $past(rec.target_position)))
    else $error("kept read not recorded");

endmodule

// File: rtl/core/rsds_square.sv
// ----------------------------------------------------------------------------
// Read statistics squared-length accumulator
// Registers the squared read length, then adds it into a saturating sum.
// ----------------------------------------------------------------------------
module rsds_square (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [rsds_pkg::LEN_W-1:0]    read_length,
  input  logic                          adv,
  output logic [rsds_pkg::SQ_W-1:0]     total_next
);

  logic [rsds_pkg::PROD_W-1:0] prod;
  logic [rsds_pkg::SQ_W-1:0]   sq_acc;
  logic [rsds_pkg::SQ_W:0]     sq_sum;

  // The product register travels alongside the second pipeline stage.
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= read_length * read_length;
    end
  end

  always_comb begin
    sq_sum     = {1'b0, sq_acc} + (rsds_pkg::SQ_W + 1)'(prod);
    total_next = sq_sum[rsds_pkg::SQ_W] ? '1 : sq_sum[rsds_pkg::SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_acc <= '0;
    end else if (adv) begin
      sq_acc <= total_next;
    end
  end

endmodule
